>>> src/tcb_pkg.sv
// Shared constants for the triangle clamp and barycentric weight core.
package tcb_pkg;

   // Default geometry of the number formats
   localparam int COORD_WIDTH_DEF      = 16;
   localparam int COORD_FRAC_BITS_DEF  = 4;
   localparam int WEIGHT_FRAC_BITS_DEF = 15;

   // Fraction bits of the projection parameter along an edge
   localparam int T_BITS = 32;

   // Quotient bits resolved in each divider stage
   localparam int DIV_STEPS = 4;

   // Register file
   localparam int CSR_ADDR_W = 3;
   localparam logic [CSR_ADDR_W-1:0] REG_TOP_X   = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_TOP_Y   = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_LEFT_X  = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_LEFT_Y  = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_RIGHT_X = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] REG_RIGHT_Y = 3'd5;

   localparam int TOP_X_RESET   = 5600;
   localparam int TOP_Y_RESET   = 1280;
   localparam int LEFT_X_RESET  = 1280;
   localparam int LEFT_Y_RESET  = 7520;
   localparam int RIGHT_X_RESET = 9920;
   localparam int RIGHT_Y_RESET = 7520;

   // Projection outcome per edge
   localparam logic [1:0] PMODE_START = 2'd0;
   localparam logic [1:0] PMODE_END   = 2'd1;
   localparam logic [1:0] PMODE_MID   = 2'd2;

   // Weight outcome per vertex
   localparam logic [1:0] WMODE_ZERO = 2'd0;
   localparam logic [1:0] WMODE_ONE  = 2'd1;
   localparam logic [1:0] WMODE_DIV  = 2'd2;

endpackage

>>> src/tcb_frac_div.sv
// Pipelined restoring fractional divider: floor(num * 2^Q_BITS / den), num < den.
module tcb_frac_div #(
   parameter int NUM_W  = 35,
   parameter int Q_BITS = 32,
   parameter int SIDE_W = 1
) (
   input  logic                clock,
   input  logic [((Q_BITS+tcb_pkg::DIV_STEPS-1)/tcb_pkg::DIV_STEPS)-1:0] en,
   input  logic [NUM_W-1:0]    num_i,
   input  logic [NUM_W-1:0]    den_i,
   input  logic [SIDE_W-1:0]   side_i,
   output logic [Q_BITS-1:0]   quo_o,
   output logic [SIDE_W-1:0]   side_o
);
   import tcb_pkg::*;

   localparam int STAGES = (Q_BITS + DIV_STEPS - 1) / DIV_STEPS;

   logic [NUM_W-1:0]  rem_ff  [STAGES];
   logic [NUM_W-1:0]  den_ff  [STAGES];
   logic [Q_BITS-1:0] quo_ff  [STAGES];
   logic [SIDE_W-1:0] side_ff [STAGES];

   for (genvar s = 0; s < STAGES; s++) begin : g_stage
      logic [NUM_W-1:0]  rem_src;
      logic [NUM_W-1:0]  den_src;
      logic [Q_BITS-1:0] quo_src;
      logic [SIDE_W-1:0] side_src;
      logic [NUM_W-1:0]  rem_in;
      logic [Q_BITS-1:0] quo_in;
      logic [NUM_W:0]    trial;

      if (s == 0) begin : g_first
         assign rem_src  = num_i;
         assign den_src  = den_i;
         assign quo_src  = '0;
         assign side_src = side_i;
      end else begin : g_next
         assign rem_src  = rem_ff[s-1];
         assign den_src  = den_ff[s-1];
         assign quo_src  = quo_ff[s-1];
         assign side_src = side_ff[s-1];
      end

      // Resolve a few quotient bits: shift, compare, subtract
      always_comb begin
         rem_in = rem_src;
         quo_in = quo_src;
         trial  = '0;
         for (int i = 0; i < DIV_STEPS; i++) begin
            if (s * DIV_STEPS + i < Q_BITS) begin
               trial  = {rem_in, 1'b0};
               quo_in = {quo_in[Q_BITS-2:0], 1'b0};
               if (trial >= {1'b0, den_src}) begin
                  trial     = trial - {1'b0, den_src};
                  quo_in[0] = 1'b1;
               end
               rem_in = trial[NUM_W-1:0];
            end
         end
      end

      // Advance the stage
      always_ff @(posedge clock) begin
         if (en[s]) begin
            rem_ff[s]  <= rem_in;
            den_ff[s]  <= den_src;
            quo_ff[s]  <= quo_in;
            side_ff[s] <= side_src;
         end
      end
   end

   assign quo_o  = quo_ff[STAGES-1];
   assign side_o = side_ff[STAGES-1];

endmodule

>>> src/tcb_project.sv
// Inside test and clamp of a point onto the nearest triangle edge.
module tcb_project #(
   parameter int COORD_WIDTH = tcb_pkg::COORD_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic [9+((tcb_pkg::T_BITS+tcb_pkg::DIV_STEPS-1)/tcb_pkg::DIV_STEPS)-1:0] en,
   input  logic signed [COORD_WIDTH-1:0]  point_x,
   input  logic signed [COORD_WIDTH-1:0]  point_y,
   input  logic signed [COORD_WIDTH-1:0]  vx_i [3],
   input  logic signed [COORD_WIDTH-1:0]  vy_i [3],
   input  logic signed [COORD_WIDTH:0]    ex_i [3],
   input  logic signed [COORD_WIDTH:0]    ey_i [3],
   input  logic [2*COORD_WIDTH+2:0]       len_i [3],
   input  logic                           short_i [3],
   output logic signed [COORD_WIDTH-1:0]  cx_o,
   output logic signed [COORD_WIDTH-1:0]  cy_o,
   output logic                           inside_o
);
   import tcb_pkg::*;

   localparam int CW   = COORD_WIDTH;
   localparam int DW   = CW + 1;
   localparam int PW   = 2 * DW;
   localparam int AW   = PW + 1;
   localparam int DST  = (T_BITS + DIV_STEPS - 1) / DIV_STEPS;
   localparam int SW0  = 2 * CW + 3;
   localparam int E_P1 = 0;
   localparam int E_P2 = 1;
   localparam int E_P3 = 2;
   localparam int E_P4 = 3;
   localparam int E_DV = 4;
   localparam int E_P5 = 4 + DST;
   localparam int E_P6 = 5 + DST;
   localparam int E_P7 = 6 + DST;
   localparam int E_P8 = 7 + DST;
   localparam int E_P9 = 8 + DST;

   // Stage 1: offsets from each edge start
   logic signed [CW-1:0] px1_ff, py1_ff;
   logic signed [DW-1:0] wx1_ff [3];
   logic signed [DW-1:0] wy1_ff [3];

   always_ff @(posedge clock) begin
      if (en[E_P1]) begin
         px1_ff <= point_x;
         py1_ff <= point_y;
         for (int k = 0; k < 3; k++) begin
            wx1_ff[k] <= DW'(point_x) - DW'(vx_i[k]);
            wy1_ff[k] <= DW'(point_y) - DW'(vy_i[k]);
         end
      end
   end

   // Stage 2: dot and cross products
   logic signed [CW-1:0] px2_ff, py2_ff;
   logic signed [PW-1:0] pdx2_ff [3];
   logic signed [PW-1:0] pdy2_ff [3];
   logic signed [PW-1:0] pca2_ff [3];
   logic signed [PW-1:0] pcb2_ff [3];

   always_ff @(posedge clock) begin
      if (en[E_P2]) begin
         px2_ff <= px1_ff;
         py2_ff <= py1_ff;
         for (int k = 0; k < 3; k++) begin
            pdx2_ff[k] <= PW'(wx1_ff[k]) * PW'(ex_i[k]);
            pdy2_ff[k] <= PW'(wy1_ff[k]) * PW'(ey_i[k]);
            pca2_ff[k] <= PW'(ex_i[k]) * PW'(wy1_ff[(k+1)%3]);
            pcb2_ff[k] <= PW'(ey_i[k]) * PW'(wx1_ff[(k+1)%3]);
         end
      end
   end

   // Stage 3: edge areas give the inside flag; keep the dot products
   logic signed [AW-1:0] area3 [3];
   logic                 neg3, pos3;
   logic signed [CW-1:0] px3_ff, py3_ff;
   logic signed [AW-1:0] dot3_ff [3];
   logic                 inside3_ff;

   always_comb begin
      neg3 = 1'b0;
      pos3 = 1'b0;
      for (int k = 0; k < 3; k++) begin
         area3[k] = AW'(pca2_ff[k]) - AW'(pcb2_ff[k]);
         if (area3[k][AW-1]) neg3 = 1'b1;
         else if (area3[k] != '0) pos3 = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (en[E_P3]) begin
         px3_ff     <= px2_ff;
         py3_ff     <= py2_ff;
         inside3_ff <= !(neg3 && pos3);
         for (int k = 0; k < 3; k++) begin
            dot3_ff[k] <= AW'(pdx2_ff[k]) + AW'(pdy2_ff[k]);
         end
      end
   end

   // Stage 4: limit the projection parameter before dividing
   logic [1:0]           mode4_in [3];
   logic signed [CW-1:0] px4_ff, py4_ff;
   logic                 inside4_ff;
   logic [1:0]           mode4_ff [3];
   logic [AW-1:0]        num4_ff  [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         if (short_i[k] || dot3_ff[k][AW-1] || dot3_ff[k] == '0) begin
            mode4_in[k] = PMODE_START;
         end else if ($unsigned(dot3_ff[k]) >= len_i[k]) begin
            mode4_in[k] = PMODE_END;
         end else begin
            mode4_in[k] = PMODE_MID;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[E_P4]) begin
         px4_ff     <= px3_ff;
         py4_ff     <= py3_ff;
         inside4_ff <= inside3_ff;
         for (int k = 0; k < 3; k++) begin
            mode4_ff[k] <= mode4_in[k];
            num4_ff[k]  <= $unsigned(dot3_ff[k]);
         end
      end
   end

   // Projection parameter dividers, one per edge
   logic [T_BITS-1:0] t_q    [3];
   logic [SW0-1:0]    side0_o;
   logic [1:0]        side1_o, side2_o;

   tcb_frac_div #(.NUM_W(AW), .Q_BITS(T_BITS), .SIDE_W(SW0)) u_div0 (
      .clock  (clock),
      .en     (en[E_DV +: DST]),
      .num_i  (num4_ff[0]),
      .den_i  (len_i[0]),
      .side_i ({inside4_ff, mode4_ff[0], py4_ff, px4_ff}),
      .quo_o  (t_q[0]),
      .side_o (side0_o)
   );

   tcb_frac_div #(.NUM_W(AW), .Q_BITS(T_BITS), .SIDE_W(2)) u_div1 (
      .clock  (clock),
      .en     (en[E_DV +: DST]),
      .num_i  (num4_ff[1]),
      .den_i  (len_i[1]),
      .side_i (mode4_ff[1]),
      .quo_o  (t_q[1]),
      .side_o (side1_o)
   );

   tcb_frac_div #(.NUM_W(AW), .Q_BITS(T_BITS), .SIDE_W(2)) u_div2 (
      .clock  (clock),
      .en     (en[E_DV +: DST]),
      .num_i  (num4_ff[2]),
      .den_i  (len_i[2]),
      .side_i (mode4_ff[2]),
      .quo_o  (t_q[2]),
      .side_o (side2_o)
   );

   // Stage 5: scale the edge length by the parameter
   logic [DW-1:0]          mag_x [3];
   logic [DW-1:0]          mag_y [3];
   logic signed [CW-1:0]   px5_ff, py5_ff;
   logic                   inside5_ff;
   logic [1:0]             mode5_ff [3];
   logic [T_BITS+DW-1:0]   sx5_ff [3];
   logic [T_BITS+DW-1:0]   sy5_ff [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         mag_x[k] = ex_i[k][DW-1] ? DW'(-ex_i[k]) : DW'(ex_i[k]);
         mag_y[k] = ey_i[k][DW-1] ? DW'(-ey_i[k]) : DW'(ey_i[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (en[E_P5]) begin
         px5_ff      <= side0_o[CW-1:0];
         py5_ff      <= side0_o[2*CW-1:CW];
         mode5_ff[0] <= side0_o[2*CW+1:2*CW];
         inside5_ff  <= side0_o[2*CW+2];
         mode5_ff[1] <= side1_o;
         mode5_ff[2] <= side2_o;
         for (int k = 0; k < 3; k++) begin
            sx5_ff[k] <= (T_BITS+DW)'(t_q[k]) * (T_BITS+DW)'(mag_x[k]);
            sy5_ff[k] <= (T_BITS+DW)'(t_q[k]) * (T_BITS+DW)'(mag_y[k]);
         end
      end
   end

   // Stage 6: projected point on each edge
   logic [DW-1:0]        offx, offy;
   logic signed [DW-1:0] sumx, sumy;
   logic signed [CW-1:0] qx6_in [3];
   logic signed [CW-1:0] qy6_in [3];
   logic signed [CW-1:0] px6_ff, py6_ff;
   logic                 inside6_ff;
   logic signed [CW-1:0] qx6_ff [3];
   logic signed [CW-1:0] qy6_ff [3];

   always_comb begin
      offx = '0;
      offy = '0;
      sumx = '0;
      sumy = '0;
      for (int k = 0; k < 3; k++) begin
         offx = sx5_ff[k][T_BITS +: DW];
         offy = sy5_ff[k][T_BITS +: DW];
         sumx = ex_i[k][DW-1] ? DW'(vx_i[k]) - $signed(offx) : DW'(vx_i[k]) + $signed(offx);
         sumy = ey_i[k][DW-1] ? DW'(vy_i[k]) - $signed(offy) : DW'(vy_i[k]) + $signed(offy);
         case (mode5_ff[k])
            PMODE_END: begin
               qx6_in[k] = vx_i[(k+1)%3];
               qy6_in[k] = vy_i[(k+1)%3];
            end
            PMODE_MID: begin
               qx6_in[k] = sumx[CW-1:0];
               qy6_in[k] = sumy[CW-1:0];
            end
            default: begin
               qx6_in[k] = vx_i[k];
               qy6_in[k] = vy_i[k];
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (en[E_P6]) begin
         px6_ff     <= px5_ff;
         py6_ff     <= py5_ff;
         inside6_ff <= inside5_ff;
         for (int k = 0; k < 3; k++) begin
            qx6_ff[k] <= qx6_in[k];
            qy6_ff[k] <= qy6_in[k];
         end
      end
   end

   // Stage 7: squared distance terms
   logic signed [DW-1:0] ddx7 [3];
   logic signed [DW-1:0] ddy7 [3];
   logic signed [CW-1:0] px7_ff, py7_ff;
   logic                 inside7_ff;
   logic signed [CW-1:0] qx7_ff [3];
   logic signed [CW-1:0] qy7_ff [3];
   logic signed [PW-1:0] sqx7_ff [3];
   logic signed [PW-1:0] sqy7_ff [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         ddx7[k] = DW'(qx6_ff[k]) - DW'(px6_ff);
         ddy7[k] = DW'(qy6_ff[k]) - DW'(py6_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (en[E_P7]) begin
         px7_ff     <= px6_ff;
         py7_ff     <= py6_ff;
         inside7_ff <= inside6_ff;
         for (int k = 0; k < 3; k++) begin
            qx7_ff[k]  <= qx6_ff[k];
            qy7_ff[k]  <= qy6_ff[k];
            sqx7_ff[k] <= PW'(ddx7[k]) * PW'(ddx7[k]);
            sqy7_ff[k] <= PW'(ddy7[k]) * PW'(ddy7[k]);
         end
      end
   end

   // Stage 8: squared distances
   logic signed [CW-1:0] px8_ff, py8_ff;
   logic                 inside8_ff;
   logic signed [CW-1:0] qx8_ff [3];
   logic signed [CW-1:0] qy8_ff [3];
   logic [AW-1:0]        dist8_ff [3];

   always_ff @(posedge clock) begin
      if (en[E_P8]) begin
         px8_ff     <= px7_ff;
         py8_ff     <= py7_ff;
         inside8_ff <= inside7_ff;
         for (int k = 0; k < 3; k++) begin
            qx8_ff[k]   <= qx7_ff[k];
            qy8_ff[k]   <= qy7_ff[k];
            dist8_ff[k] <= AW'($unsigned(sqx7_ff[k])) + AW'($unsigned(sqy7_ff[k]));
         end
      end
   end

   // Stage 9: keep an inside point, else take the nearest projection (earlier edge on ties)
   logic signed [CW-1:0] cx9_in, cy9_in;
   logic signed [CW-1:0] cx9_ff, cy9_ff;
   logic                 inside9_ff;

   always_comb begin
      if (inside8_ff) begin
         cx9_in = px8_ff;
         cy9_in = py8_ff;
      end else if (dist8_ff[0] <= dist8_ff[1] && dist8_ff[0] <= dist8_ff[2]) begin
         cx9_in = qx8_ff[0];
         cy9_in = qy8_ff[0];
      end else if (dist8_ff[1] <= dist8_ff[2]) begin
         cx9_in = qx8_ff[1];
         cy9_in = qy8_ff[1];
      end else begin
         cx9_in = qx8_ff[2];
         cy9_in = qy8_ff[2];
      end
   end

   always_ff @(posedge clock) begin
      if (en[E_P9]) begin
         cx9_ff     <= cx9_in;
         cy9_ff     <= cy9_in;
         inside9_ff <= inside8_ff;
      end
   end

   assign cx_o     = cx9_ff;
   assign cy_o     = cy9_ff;
   assign inside_o = inside9_ff;

endmodule

>>> src/tcb_weight.sv
// Barycentric weights of the clamped point as sub-area over total area.
module tcb_weight #(
   parameter int COORD_WIDTH      = tcb_pkg::COORD_WIDTH_DEF,
   parameter int WEIGHT_FRAC_BITS = tcb_pkg::WEIGHT_FRAC_BITS_DEF
) (
   input  logic                           clock,
   input  logic [5+((WEIGHT_FRAC_BITS+tcb_pkg::DIV_STEPS-1)/tcb_pkg::DIV_STEPS)-1:0] en,
   input  logic signed [COORD_WIDTH-1:0]  cx_i,
   input  logic signed [COORD_WIDTH-1:0]  cy_i,
   input  logic                           inside_i,
   input  logic signed [COORD_WIDTH-1:0]  vx_i [3],
   input  logic signed [COORD_WIDTH-1:0]  vy_i [3],
   input  logic signed [COORD_WIDTH:0]    ex_i [3],
   input  logic signed [COORD_WIDTH:0]    ey_i [3],
   input  logic                           tneg_i,
   input  logic [2*COORD_WIDTH+2:0]       tmag_i,
   output logic [WEIGHT_FRAC_BITS:0]      wt_o [3],
   output logic signed [COORD_WIDTH-1:0]  cx_o,
   output logic signed [COORD_WIDTH-1:0]  cy_o,
   output logic                           inside_o
);
   import tcb_pkg::*;

   localparam int CW   = COORD_WIDTH;
   localparam int WB   = WEIGHT_FRAC_BITS;
   localparam int DW   = CW + 1;
   localparam int PW   = 2 * DW;
   localparam int AW   = PW + 1;
   localparam int DST  = (WB + DIV_STEPS - 1) / DIV_STEPS;
   localparam int SW0  = 2 * CW + 3;
   localparam int E_W1 = 0;
   localparam int E_W2 = 1;
   localparam int E_W3 = 2;
   localparam int E_W4 = 3;
   localparam int E_DV = 4;
   localparam int E_W5 = 4 + DST;

   // Stage 1: offsets of the clamped point from each vertex
   logic signed [CW-1:0] cx1_ff, cy1_ff;
   logic                 inside1_ff;
   logic signed [DW-1:0] wx1_ff [3];
   logic signed [DW-1:0] wy1_ff [3];

   always_ff @(posedge clock) begin
      if (en[E_W1]) begin
         cx1_ff     <= cx_i;
         cy1_ff     <= cy_i;
         inside1_ff <= inside_i;
         for (int k = 0; k < 3; k++) begin
            wx1_ff[k] <= DW'(cx_i) - DW'(vx_i[k]);
            wy1_ff[k] <= DW'(cy_i) - DW'(vy_i[k]);
         end
      end
   end

   // Stage 2: cross products; weight j uses the edge opposite vertex j
   logic signed [CW-1:0] cx2_ff, cy2_ff;
   logic                 inside2_ff;
   logic signed [PW-1:0] pa2_ff [3];
   logic signed [PW-1:0] pb2_ff [3];

   always_ff @(posedge clock) begin
      if (en[E_W2]) begin
         cx2_ff     <= cx1_ff;
         cy2_ff     <= cy1_ff;
         inside2_ff <= inside1_ff;
         for (int j = 0; j < 3; j++) begin
            pa2_ff[j] <= PW'(ex_i[(j+1)%3]) * PW'(wy1_ff[(j+2)%3]);
            pb2_ff[j] <= PW'(ey_i[(j+1)%3]) * PW'(wx1_ff[(j+2)%3]);
         end
      end
   end

   // Stage 3: sub-areas
   logic signed [CW-1:0] cx3_ff, cy3_ff;
   logic                 inside3_ff;
   logic signed [AW-1:0] area3_ff [3];

   always_ff @(posedge clock) begin
      if (en[E_W3]) begin
         cx3_ff     <= cx2_ff;
         cy3_ff     <= cy2_ff;
         inside3_ff <= inside2_ff;
         for (int j = 0; j < 3; j++) begin
            area3_ff[j] <= AW'(pa2_ff[j]) - AW'(pb2_ff[j]);
         end
      end
   end

   // Stage 4: sort out zero, full and fractional weights
   logic [AW-1:0]        amag4    [3];
   logic [1:0]           mode4_in [3];
   logic signed [CW-1:0] cx4_ff, cy4_ff;
   logic                 inside4_ff;
   logic [1:0]           mode4_ff [3];
   logic [AW-1:0]        num4_ff  [3];

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         amag4[j] = area3_ff[j][AW-1] ? AW'(-area3_ff[j]) : AW'(area3_ff[j]);
         if (area3_ff[j] == '0 || area3_ff[j][AW-1] != tneg_i) begin
            mode4_in[j] = WMODE_ZERO;
         end else if (amag4[j] >= tmag_i) begin
            mode4_in[j] = WMODE_ONE;
         end else begin
            mode4_in[j] = WMODE_DIV;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[E_W4]) begin
         cx4_ff     <= cx3_ff;
         cy4_ff     <= cy3_ff;
         inside4_ff <= inside3_ff;
         for (int j = 0; j < 3; j++) begin
            mode4_ff[j] <= mode4_in[j];
            num4_ff[j]  <= amag4[j];
         end
      end
   end

   // Weight dividers, one per vertex
   logic [WB-1:0]  w_q [3];
   logic [SW0-1:0] side0_o;
   logic [1:0]     side1_o, side2_o;

   tcb_frac_div #(.NUM_W(AW), .Q_BITS(WB), .SIDE_W(SW0)) u_div0 (
      .clock  (clock),
      .en     (en[E_DV +: DST]),
      .num_i  (num4_ff[0]),
      .den_i  (tmag_i),
      .side_i ({inside4_ff, mode4_ff[0], cy4_ff, cx4_ff}),
      .quo_o  (w_q[0]),
      .side_o (side0_o)
   );

   tcb_frac_div #(.NUM_W(AW), .Q_BITS(WB), .SIDE_W(2)) u_div1 (
      .clock  (clock),
      .en     (en[E_DV +: DST]),
      .num_i  (num4_ff[1]),
      .den_i  (tmag_i),
      .side_i (mode4_ff[1]),
      .quo_o  (w_q[1]),
      .side_o (side1_o)
   );

   tcb_frac_div #(.NUM_W(AW), .Q_BITS(WB), .SIDE_W(2)) u_div2 (
      .clock  (clock),
      .en     (en[E_DV +: DST]),
      .num_i  (num4_ff[2]),
      .den_i  (tmag_i),
      .side_i (mode4_ff[2]),
      .quo_o  (w_q[2]),
      .side_o (side2_o)
   );

   // Stage 5: output word
   logic [1:0]           mode5 [3];
   logic [WB:0]          wt5_in [3];
   logic [WB:0]          wt5_ff [3];
   logic signed [CW-1:0] cx5_ff, cy5_ff;
   logic                 inside5_ff;

   assign mode5[0] = side0_o[2*CW+1:2*CW];
   assign mode5[1] = side1_o;
   assign mode5[2] = side2_o;

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         case (mode5[j])
            WMODE_ONE: wt5_in[j] = {1'b1, {WB{1'b0}}};
            WMODE_DIV: wt5_in[j] = {1'b0, w_q[j]};
            default:   wt5_in[j] = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (en[E_W5]) begin
         cx5_ff     <= side0_o[CW-1:0];
         cy5_ff     <= side0_o[2*CW-1:CW];
         inside5_ff <= side0_o[2*CW+2];
         for (int j = 0; j < 3; j++) begin
            wt5_ff[j] <= wt5_in[j];
         end
      end
   end

   assign wt_o     = wt5_ff;
   assign cx_o     = cx5_ff;
   assign cy_o     = cy5_ff;
   assign inside_o = inside5_ff;

endmodule

>>> src/triangle_clamp_barycentric_core.sv
// Top level: point clamp into a triangle and barycentric weights, fully pipelined.
//
// One point enters per cycle while the result side does not stall. The pipeline depth is
// set by the 32-bit projection parameter dividers and the weight dividers (W = 15 weight
// fraction bits by default), each resolving four quotient bits per stage. Every stage
// holds its word when the next stage is full and stalled, so bubbles are squeezed out
// and no word is dropped or repeated. The triangle lives in six vertex registers;
// derived edge lengths and total area are registered after a write, so write them only
// while no points are in flight.
module triangle_clamp_barycentric_core #(
   parameter int COORD_WIDTH      = tcb_pkg::COORD_WIDTH_DEF,
   parameter int COORD_FRAC_BITS  = tcb_pkg::COORD_FRAC_BITS_DEF,
   parameter int WEIGHT_FRAC_BITS = tcb_pkg::WEIGHT_FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // point_x, point_y
   input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]  req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // weight_top, weight_left, weight_right, clamped_x, clamped_y, was_inside
   output logic [((3*WEIGHT_FRAC_BITS+2*COORD_WIDTH+4+7)/8)*8-1:0] rsp_tdata,
   input  logic                                csr_we,
   input  logic [tcb_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  logic [COORD_WIDTH-1:0]              csr_wdata
);
   import tcb_pkg::*;

   localparam int CW        = COORD_WIDTH;
   localparam int WB        = WEIGHT_FRAC_BITS;
   localparam int DW        = CW + 1;
   localparam int PW        = 2 * DW;
   localparam int AW        = PW + 1;
   localparam int RW        = 3 * (WB + 1) + 2 * CW + 1;
   localparam int RB        = ((RW + 7) / 8) * 8;
   localparam int PST       = 9 + (T_BITS + DIV_STEPS - 1) / DIV_STEPS;
   localparam int WST       = 5 + (WB + DIV_STEPS - 1) / DIV_STEPS;
   localparam int NST       = PST + WST;
   localparam int ONE_SQ    = 1 << (2 * COORD_FRAC_BITS);
   localparam int SMALL_LIM = (ONE_SQ + 999) / 1000;

   // Vertex registers
   logic signed [CW-1:0] top_x_ff, top_y_ff, left_x_ff, left_y_ff, right_x_ff, right_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         top_x_ff   <= CW'(TOP_X_RESET);
         top_y_ff   <= CW'(TOP_Y_RESET);
         left_x_ff  <= CW'(LEFT_X_RESET);
         left_y_ff  <= CW'(LEFT_Y_RESET);
         right_x_ff <= CW'(RIGHT_X_RESET);
         right_y_ff <= CW'(RIGHT_Y_RESET);
      end else if (csr_we) begin
         case (csr_addr)
            REG_TOP_X:   top_x_ff   <= csr_wdata;
            REG_TOP_Y:   top_y_ff   <= csr_wdata;
            REG_LEFT_X:  left_x_ff  <= csr_wdata;
            REG_LEFT_Y:  left_y_ff  <= csr_wdata;
            REG_RIGHT_X: right_x_ff <= csr_wdata;
            REG_RIGHT_Y: right_y_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Vertices in edge order and edge vectors top-left, left-right, right-top
   logic signed [CW-1:0] vx [3];
   logic signed [CW-1:0] vy [3];
   logic signed [DW-1:0] ex [3];
   logic signed [DW-1:0] ey [3];

   assign vx[0] = top_x_ff;
   assign vy[0] = top_y_ff;
   assign vx[1] = left_x_ff;
   assign vy[1] = left_y_ff;
   assign vx[2] = right_x_ff;
   assign vy[2] = right_y_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         ex[k] = DW'(vx[(k+1)%3]) - DW'(vx[k]);
         ey[k] = DW'(vy[(k+1)%3]) - DW'(vy[k]);
      end
   end

   // Edge lengths squared
   logic signed [PW-1:0] lsqx_ff [3];
   logic signed [PW-1:0] lsqy_ff [3];
   logic [AW-1:0]        len_ff  [3];
   logic                 short_edge [3];

   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         lsqx_ff[k] <= PW'(ex[k]) * PW'(ex[k]);
         lsqy_ff[k] <= PW'(ey[k]) * PW'(ey[k]);
         len_ff[k]  <= AW'($unsigned(lsqx_ff[k])) + AW'($unsigned(lsqy_ff[k]));
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         short_edge[k] = len_ff[k] < AW'(SMALL_LIM);
      end
   end

   // Total area; a flat triangle counts as unit area
   logic signed [PW-1:0] tpa_ff, tpb_ff;
   logic signed [AW-1:0] total_ff;
   logic [AW-1:0]        tabs;
   logic [AW-1:0]        tmag_ff;
   logic                 tneg_ff;

   assign tabs = total_ff[AW-1] ? AW'(-total_ff) : AW'(total_ff);

   always_ff @(posedge clock) begin
      tpa_ff   <= PW'(DW'(top_x_ff) - DW'(right_x_ff)) * PW'(DW'(left_y_ff) - DW'(right_y_ff));
      tpb_ff   <= PW'(DW'(left_x_ff) - DW'(right_x_ff)) * PW'(DW'(top_y_ff) - DW'(right_y_ff));
      total_ff <= AW'(tpa_ff) - AW'(tpb_ff);
      if (tabs < AW'(SMALL_LIM)) begin
         tmag_ff <= AW'(ONE_SQ);
         tneg_ff <= 1'b0;
      end else begin
         tmag_ff <= tabs;
         tneg_ff <= total_ff[AW-1];
      end
   end

   // Stage valid bits and per-stage advance
   logic [NST-1:0] valid_ff;
   logic [NST-1:0] adv;

   always_comb begin
      adv[NST-1] = !valid_ff[NST-1] || rsp_tready;
      for (int s = NST - 2; s >= 0; s--) begin
         adv[s] = !valid_ff[s] || adv[s+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (adv[0]) valid_ff[0] <= req_tvalid;
         for (int s = 1; s < NST; s++) begin
            if (adv[s]) valid_ff[s] <= valid_ff[s-1];
         end
      end
   end

   assign req_tready = adv[0];
   assign rsp_tvalid = valid_ff[NST-1];

   // Clamp front end
   logic signed [CW-1:0] cx_p, cy_p;
   logic                 inside_p;

   tcb_project #(.COORD_WIDTH(CW)) u_project (
      .clock    (clock),
      .en       (adv[PST-1:0]),
      .point_x  ($signed(req_tdata[CW-1:0])),
      .point_y  ($signed(req_tdata[2*CW-1:CW])),
      .vx_i     (vx),
      .vy_i     (vy),
      .ex_i     (ex),
      .ey_i     (ey),
      .len_i    (len_ff),
      .short_i  (short_edge),
      .cx_o     (cx_p),
      .cy_o     (cy_p),
      .inside_o (inside_p)
   );

   // Weight back end
   logic [WB:0]          wt [3];
   logic signed [CW-1:0] cx_w, cy_w;
   logic                 inside_w;

   tcb_weight #(.COORD_WIDTH(CW), .WEIGHT_FRAC_BITS(WB)) u_weight (
      .clock    (clock),
      .en       (adv[NST-1:PST]),
      .cx_i     (cx_p),
      .cy_i     (cy_p),
      .inside_i (inside_p),
      .vx_i     (vx),
      .vy_i     (vy),
      .ex_i     (ex),
      .ey_i     (ey),
      .tneg_i   (tneg_ff),
      .tmag_i   (tmag_ff),
      .wt_o     (wt),
      .cx_o     (cx_w),
      .cy_o     (cy_w),
      .inside_o (inside_w)
   );

   // Pack the result word
   assign rsp_tdata = RB'({inside_w, cy_w, cx_w, wt[2], wt[1], wt[0]});

endmodule

>>> test/tb_triangle_clamp_barycentric_core.sv
// Testbench for the triangle clamp and barycentric weight core.
`timescale 1ns / 100ps

module tb_triangle_clamp_barycentric_core;
   import tcb_pkg::*;

   localparam int CW        = COORD_WIDTH_DEF;
   localparam int CFB       = COORD_FRAC_BITS_DEF;
   localparam int WFB       = WEIGHT_FRAC_BITS_DEF;
   localparam int REQ_W     = ((2*CW+7)/8)*8;
   localparam int RSP_W     = ((3*WFB+2*CW+4+7)/8)*8;
   localparam int WW        = WFB + 1;
   localparam longint SQ_ONE    = longint'(1) << (2*CFB);
   localparam longint TINY_AREA = (SQ_ONE + 999) / 1000;
   localparam longint W_ONE     = longint'(1) << WFB;
   localparam logic [CSR_ADDR_W-1:0] REG_BEYOND = 3'd7;
   localparam int SETTLE_CYCLES  = 40;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int LONG_HOLD      = 400;
   localparam int PHASES         = 8;
   localparam int POINTS_PER_PHASE = 200;

   typedef struct {
      logic [WW-1:0]        w_top;
      logic [WW-1:0]        w_left;
      logic [WW-1:0]        w_right;
      logic signed [CW-1:0] cx;
      logic signed [CW-1:0] cy;
      logic                 in_tri;
   } tri_result_type;

   // Predict clamped point and weights per accepted point, check words in order
   class scoreboard_type;
      longint         vtx[6];
      tri_result_type expected_q[$];
      int             errors;

      function new();
         vtx[0] = TOP_X_RESET;  vtx[1] = TOP_Y_RESET;
         vtx[2] = LEFT_X_RESET; vtx[3] = LEFT_Y_RESET;
         vtx[4] = RIGHT_X_RESET; vtx[5] = RIGHT_Y_RESET;
         errors = 0;
      endfunction

      function void write_reg(int idx, logic [CW-1:0] v);
         if (idx < 6) vtx[idx] = longint'($signed(v));
      endfunction

      function longint tri_area(longint ax, ay, bx, by, cx, cy);
         return (ax - cx) * (by - cy) - (bx - cx) * (ay - cy);
      endfunction

      // floor(num * 2^bits / den), num < den
      function longint frac_quot(longint num, longint den, int bits);
         longint q, r;
         q = 0;
         r = num;
         for (int i = 0; i < bits; i++) begin
            r = r <<< 1;
            q = q <<< 1;
            if (r >= den) begin
               r = r - den;
               q = q | 1;
            end
         end
         return q;
      endfunction

      function longint along(longint t, longint d);
         longint m, o;
         m = d < 0 ? -d : d;
         o = (t * m) >>> T_BITS;
         return d < 0 ? -o : o;
      endfunction

      function void project_edge(longint px, py, ax, ay, bx, by,
                                 output longint ox, output longint oy);
         longint dx, dy, len, dot, t;
         dx = bx - ax;
         dy = by - ay;
         len = dx * dx + dy * dy;
         ox = ax;
         oy = ay;
         if (len < TINY_AREA) return;
         dot = (px - ax) * dx + (py - ay) * dy;
         if (dot <= 0) return;
         if (dot >= len) begin
            ox = bx;
            oy = by;
            return;
         end
         t = frac_quot(dot, len, T_BITS);
         ox = ax + along(t, dx);
         oy = ay + along(t, dy);
      endfunction

      function longint vertex_weight(longint a, longint total);
         longint am, tm;
         if (a == 0 || ((a < 0) != (total < 0))) return 0;
         am = a < 0 ? -a : a;
         tm = total < 0 ? -total : total;
         if (am >= tm) return W_ONE;
         return frac_quot(am, tm, WFB);
      endfunction

      function void note_point(logic signed [CW-1:0] px_in, logic signed [CW-1:0] py_in);
         longint px, py, cx, cy, d1, d2, d3, total, tmag;
         longint x1, y1, x2, y2, x3, y3, e1, e2, e3;
         logic neg, pos;
         tri_result_type r;
         px = px_in;
         py = py_in;
         cx = px;
         cy = py;
         d1 = tri_area(px, py, vtx[0], vtx[1], vtx[2], vtx[3]);
         d2 = tri_area(px, py, vtx[2], vtx[3], vtx[4], vtx[5]);
         d3 = tri_area(px, py, vtx[4], vtx[5], vtx[0], vtx[1]);
         neg = d1 < 0 || d2 < 0 || d3 < 0;
         pos = d1 > 0 || d2 > 0 || d3 > 0;
         r.in_tri = !(neg && pos);
         // outside: move to nearest edge projection, earlier edge wins ties
         if (!r.in_tri) begin
            project_edge(px, py, vtx[0], vtx[1], vtx[2], vtx[3], x1, y1);
            project_edge(px, py, vtx[2], vtx[3], vtx[4], vtx[5], x2, y2);
            project_edge(px, py, vtx[4], vtx[5], vtx[0], vtx[1], x3, y3);
            e1 = (x1 - px) * (x1 - px) + (y1 - py) * (y1 - py);
            e2 = (x2 - px) * (x2 - px) + (y2 - py) * (y2 - py);
            e3 = (x3 - px) * (x3 - px) + (y3 - py) * (y3 - py);
            if (e1 <= e2 && e1 <= e3) begin
               cx = x1; cy = y1;
            end else if (e2 <= e3) begin
               cx = x2; cy = y2;
            end else begin
               cx = x3; cy = y3;
            end
         end
         total = tri_area(vtx[0], vtx[1], vtx[2], vtx[3], vtx[4], vtx[5]);
         tmag = total < 0 ? -total : total;
         if (tmag < TINY_AREA) total = SQ_ONE;
         r.w_top   = WW'(vertex_weight(tri_area(cx, cy, vtx[2], vtx[3], vtx[4], vtx[5]), total));
         r.w_left  = WW'(vertex_weight(tri_area(cx, cy, vtx[4], vtx[5], vtx[0], vtx[1]), total));
         r.w_right = WW'(vertex_weight(tri_area(cx, cy, vtx[0], vtx[1], vtx[2], vtx[3]), total));
         r.cx = CW'(cx);
         r.cy = CW'(cy);
         expected_q.push_back(r);
      endfunction

      function void check_result(logic [RSP_W-1:0] d);
         tri_result_type e, a;
         a.w_top   = d[WW-1:0];
         a.w_left  = d[2*WW-1:WW];
         a.w_right = d[3*WW-1:2*WW];
         a.cx      = d[3*WW+CW-1:3*WW];
         a.cy      = d[3*WW+2*CW-1:3*WW+CW];
         a.in_tri  = d[3*WW+2*CW];
         if (expected_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("ERROR: unexpected result word %h", d);
            return;
         end
         e = expected_q.pop_front();
         if (a.w_top !== e.w_top || a.w_left !== e.w_left || a.w_right !== e.w_right ||
             a.cx !== e.cx || a.cy !== e.cy || a.in_tri !== e.in_tri) begin
            errors++;
            if (errors <= 10)
               $display("ERROR: exp w=%0d/%0d/%0d p=(%0d,%0d) in=%0b got w=%0d/%0d/%0d p=(%0d,%0d) in=%0b",
                        e.w_top, e.w_left, e.w_right, e.cx, e.cy, e.in_tri,
                        a.w_top, a.w_left, a.w_right, a.cx, a.cy, a.in_tri);
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_W-1:0]      req_tdata = '0;   // point_x, point_y
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_W-1:0]      rsp_tdata;        // weight_top, weight_left, weight_right,
                                            // clamped_x, clamped_y, was_inside
   logic                  csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CW-1:0]         csr_wdata = '0;

   scoreboard_type sb = new();
   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   logic long_hold_req = 1'b0;
   int  hold_left = 0;
   int  quiet_cycles = 0;

   triangle_clamp_barycentric_core dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Result side: check accepted words, stall at random or for a long hold
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
      if (long_hold_req) begin
         long_hold_req <= 1'b0;
         hold_left     <= LONG_HOLD;
         rsp_tready    <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Watchdog: count cycles with no word moving on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else
         quiet_cycles <= quiet_cycles + 1;
   end

   // Offer one point after a random gap, hold until accepted
   task automatic send_point(logic signed [CW-1:0] px, logic signed [CW-1:0] py);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tdata  <= REQ_W'({py, px});
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      sb.note_point(px, py);
   endtask

   // Wait until every expected word has come, then let the pipe go quiet
   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write all six vertices plus one out-of-range index, then let them settle
   task automatic load_triangle(longint v[6]);
      for (int i = 0; i < 7; i++) begin
         csr_we    <= 1'b1;
         csr_addr  <= (i == 6) ? REG_BEYOND : CSR_ADDR_W'(i);
         csr_wdata <= (i == 6) ? CW'($urandom) : CW'(v[i]);
         if (i < 6) sb.write_reg(i, CW'(v[i]));
         @(posedge clock);
      end
      csr_we <= 1'b0;
      repeat (10) @(posedge clock);
   endtask

   function automatic logic signed [CW-1:0] pick(longint lo, longint hi);
      if (lo < -32768) lo = -32768;
      if (hi > 32767) hi = 32767;
      return CW'(lo + longint'($urandom_range(int'(hi - lo))));
   endfunction

   initial begin
      longint v[6];
      longint mn_x, mx_x, mn_y, mx_y;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int ph = 0; ph < PHASES; ph++) begin
         if (ph < 3) begin
            send_idle_pct = 33; recv_idle_pct = 83;
         end else if (ph < 6) begin
            send_idle_pct = 83; recv_idle_pct = 33;
         end else begin
            send_idle_pct = 0; recv_idle_pct = 0;
         end
         // pick the triangle for this phase; phase 0 keeps the reset triangle
         case (ph)
            0: v = '{TOP_X_RESET, TOP_Y_RESET, LEFT_X_RESET, LEFT_Y_RESET,
                     RIGHT_X_RESET, RIGHT_Y_RESET};
            1: v = '{-32768, -32768, 32767, -32768, 0, 32767};        // widest
            2: v = '{0, 0, 1600, 1600, 3200, 3200};                   // flat
            3: v = '{100, -100, 100, -100, 100, -100};                // collapsed
            4: v = '{0, 0, 1, 0, 0, 1};                               // tiny
            5: v = '{5600, 1280, 9920, 7520, 1280, 7520};             // reversed
            6: for (int i = 0; i < 6; i++) v[i] = longint'($signed(CW'($urandom)));
            default: for (int i = 0; i < 6; i++)
               v[i] = longint'($urandom_range(8000)) - 4000;
         endcase
         if (ph != 0) load_triangle(v);

         // directed: field extremes, the vertices themselves, an edge midpoint and the centroid
         if (ph == 0) begin
            send_point(CW'(-32768), CW'(-32768));
            send_point(CW'(32767), CW'(32767));
            send_point(CW'(-32768), CW'(32767));
            send_point(CW'(32767), CW'(-32768));
            send_point(CW'(0), CW'(0));
            send_point(CW'(-1), CW'(-1));
         end
         send_point(CW'(v[0]), CW'(v[1]));
         send_point(CW'(v[2]), CW'(v[3]));
         send_point(CW'(v[4]), CW'(v[5]));
         send_point(CW'((v[0] + v[2]) / 2), CW'((v[1] + v[3]) / 2));
         send_point(CW'((v[0] + v[2] + v[4]) / 3), CW'((v[1] + v[3] + v[5]) / 3));

         mn_x = v[0]; mx_x = v[0]; mn_y = v[1]; mx_y = v[1];
         for (int i = 2; i < 6; i += 2) begin
            if (v[i] < mn_x) mn_x = v[i];
            if (v[i] > mx_x) mx_x = v[i];
            if (v[i+1] < mn_y) mn_y = v[i+1];
            if (v[i+1] > mx_y) mx_y = v[i+1];
         end
         // random: mostly around the triangle, some anywhere
         for (int n = 0; n < POINTS_PER_PHASE; n++) begin
            if (ph == 6 && n == POINTS_PER_PHASE / 2) long_hold_req <= 1'b1;
            if ($urandom_range(99) < 70)
               send_point(pick(mn_x - 2000, mx_x + 2000), pick(mn_y - 2000, mx_y + 2000));
            else
               send_point(CW'($urandom), CW'($urandom));
         end
         drain();
      end

      if (sb.errors == 0 && sb.pending() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
